/* rtl/tsed_pkg.sv */
package tsed_pkg;

    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam logic [7:0] CHAR_NUL        = 8'h00;
    localparam logic [7:0] CHAR_COLON      = 8'h3A;
    localparam logic [7:0] CHAR_CARET      = 8'h5E;
    localparam logic [7:0] CHAR_BSLASH     = 8'h5C;
    localparam logic [7:0] PAD_BYTE        = 8'h80;
    localparam logic [7:0] CTRL_MASK       = 8'h1F;
    localparam logic [7:0] PAD_LIMIT_RESET = 8'd100;
    localparam logic [7:0] REPEAT_ONE      = 8'd1;

    typedef enum logic [2:0] {
        PH_ENDED  = 3'd0,
        PH_DIGITS = 3'd1,
        PH_BODY   = 3'd2,
        PH_CARET  = 3'd3,
        PH_ESC    = 3'd4,
        PH_OCT1   = 3'd5,
        PH_OCT2   = 3'd6
    } t_phase;

    // One queue entry: up to two plain bytes, an optional pad run and the end marker.
    typedef struct packed {
        logic       has_b0;
        logic [7:0] b0;
        logic       has_b1;
        logic [7:0] b1;
        logic [7:0] pad;
        logic       has_end;
    } t_cmd;

    typedef enum logic [1:0] {
        SLOT_B0  = 2'd0,
        SLOT_B1  = 2'd1,
        SLOT_PAD = 2'd2,
        SLOT_END = 2'd3
    } t_slot;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [7:0] escape_map(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h45:   r = 8'h1B;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

/* rtl/tsed_front.sv */
module tsed_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_char,
    input  logic              i_start,
    input  logic [7:0]        i_pad_limit,
    input  logic              i_q_full,
    output logic              o_push,
    output tsed_pkg::t_cmd    o_cmd
);

    tsed_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_delay, n_delay;
    logic [7:0]       r_oct, n_oct;

    tsed_pkg::t_phase ph;
    logic [7:0]       delay_eff;
    logic [7:0]       oct_eff;
    logic [7:0]       delay_clamp;
    logic [11:0]      delay_mul;
    logic [7:0]       delay_dig;
    logic [7:0]       oct_next;
    logic [7:0]       dval;
    logic             dig;
    logic             body_end;
    logic             accept;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign ph       = i_start ? tsed_pkg::PH_DIGITS : r_phase;
    assign delay_eff = i_start ? 8'd0 : r_delay;
    assign oct_eff  = i_start ? 8'd0 : r_oct;
    assign dig      = tsed_pkg::is_digit(i_char);
    assign dval     = {4'd0, i_char[3:0]};
    assign body_end = (i_char == tsed_pkg::CHAR_NUL) || (i_char == tsed_pkg::CHAR_COLON);
    assign delay_clamp = (delay_eff > i_pad_limit) ? i_pad_limit : delay_eff;
    assign delay_mul = {4'd0, delay_eff} * 12'd10 + {4'd0, dval};
    assign delay_dig = (delay_mul > {4'd0, i_pad_limit}) ? i_pad_limit : delay_mul[7:0];
    assign oct_next = {oct_eff[4:0], 3'b000} | dval;

    // Next state.
    always_comb begin
        logic body;
        logic fin;
        body    = 1'b0;
        fin     = 1'b0;
        n_phase = ph;
        n_delay = delay_eff;
        n_oct   = oct_eff;
        case (ph)
            tsed_pkg::PH_DIGITS: begin
                if (dig) n_delay = delay_dig;
                else     body = 1'b1;
            end
            tsed_pkg::PH_BODY: body = 1'b1;
            tsed_pkg::PH_CARET: begin
                if (i_char == tsed_pkg::CHAR_NUL) fin = 1'b1;
                else n_phase = tsed_pkg::PH_BODY;
            end
            tsed_pkg::PH_ESC: begin
                if (i_char == tsed_pkg::CHAR_NUL) begin
                    fin = 1'b1;
                end else if (dig) begin
                    n_oct   = dval;
                    n_phase = tsed_pkg::PH_OCT1;
                end else begin
                    n_phase = tsed_pkg::PH_BODY;
                end
            end
            tsed_pkg::PH_OCT1, tsed_pkg::PH_OCT2: begin
                if (dig && ph == tsed_pkg::PH_OCT1) begin
                    n_oct   = oct_next;
                    n_phase = tsed_pkg::PH_OCT2;
                end else if (dig) begin
                    n_oct   = 8'd0;
                    n_phase = tsed_pkg::PH_BODY;
                end else begin
                    n_oct = 8'd0;
                    body  = 1'b1;
                end
            end
            tsed_pkg::PH_ENDED: n_phase = tsed_pkg::PH_ENDED;
            default: n_phase = tsed_pkg::PH_ENDED;
        endcase
        if (body) begin
            if (body_end)                             fin = 1'b1;
            else if (i_char == tsed_pkg::CHAR_CARET)  n_phase = tsed_pkg::PH_CARET;
            else if (i_char == tsed_pkg::CHAR_BSLASH) n_phase = tsed_pkg::PH_ESC;
            else                                      n_phase = tsed_pkg::PH_BODY;
        end
        if (fin) begin
            n_phase = tsed_pkg::PH_ENDED;
            n_delay = 8'd0;
            n_oct   = 8'd0;
        end
    end

    // Results caused by this byte.
    always_comb begin
        logic body;
        logic fin;
        body  = 1'b0;
        fin   = 1'b0;
        o_cmd = '0;
        case (ph)
            tsed_pkg::PH_DIGITS: body = !dig;
            tsed_pkg::PH_BODY:   body = 1'b1;
            tsed_pkg::PH_CARET: begin
                if (i_char == tsed_pkg::CHAR_NUL) begin
                    fin = 1'b1;
                end else begin
                    o_cmd.has_b1 = 1'b1;
                    o_cmd.b1     = i_char & tsed_pkg::CTRL_MASK;
                end
            end
            tsed_pkg::PH_ESC: begin
                if (i_char == tsed_pkg::CHAR_NUL) begin
                    fin = 1'b1;
                end else if (!dig) begin
                    o_cmd.has_b1 = 1'b1;
                    o_cmd.b1     = tsed_pkg::escape_map(i_char);
                end
            end
            tsed_pkg::PH_OCT1, tsed_pkg::PH_OCT2: begin
                if (dig && ph == tsed_pkg::PH_OCT2) begin
                    o_cmd.has_b0 = 1'b1;
                    o_cmd.b0     = oct_next;
                end else if (!dig) begin
                    // A non-digit closes the escape and is then decoded as usual.
                    o_cmd.has_b0 = 1'b1;
                    o_cmd.b0     = oct_eff;
                    body         = 1'b1;
                end
            end
            tsed_pkg::PH_ENDED: o_cmd = '0;
            default:            o_cmd = '0;
        endcase
        if (body) begin
            if (body_end) begin
                fin = 1'b1;
            end else if (i_char != tsed_pkg::CHAR_CARET &&
                         i_char != tsed_pkg::CHAR_BSLASH) begin
                o_cmd.has_b1 = 1'b1;
                o_cmd.b1     = i_char;
            end
        end
        if (fin) begin
            o_cmd.has_end = 1'b1;
            o_cmd.pad     = delay_clamp;
        end
    end

    assign o_push = accept && (o_cmd.has_b0 || o_cmd.has_b1 || o_cmd.has_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tsed_pkg::PH_ENDED;
            r_delay <= 8'd0;
            r_oct   <= 8'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_delay <= n_delay;
            r_oct   <= n_oct;
        end
    end

endmodule

/* rtl/tsed_queue.sv */
module tsed_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tsed_pkg::t_cmd    i_cmd,
    output logic              o_full,
    output logic              o_valid,
    output tsed_pkg::t_cmd    o_cmd,
    input  logic              i_pop
);

    tsed_pkg::t_cmd                  r_mem [tsed_pkg::QUEUE_DEPTH];
    logic [tsed_pkg::QUEUE_AW-1:0]   r_wr_ptr;
    logic [tsed_pkg::QUEUE_AW-1:0]   r_rd_ptr;
    logic [tsed_pkg::QUEUE_AW:0]     r_count;

    assign o_full  = (r_count == (tsed_pkg::QUEUE_AW + 1)'(tsed_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end

endmodule

/* rtl/tsed_back.sv */
module tsed_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  tsed_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic [7:0]        o_repeat,
    output logic              o_last
);

    logic [1:0]       r_step, n_step;
    logic             r_valid;
    logic [7:0]       r_byte, r_repeat;
    logic             r_last;
    logic [3:0]       present;
    tsed_pkg::t_slot  sel;
    logic             final_slot;
    logic             load;

    assign present = {i_cmd.has_end, (i_cmd.pad != 8'd0), i_cmd.has_b1, i_cmd.has_b0};
    assign load    = i_q_valid && (!r_valid || i_ready);

    // Pick the first pending result of the head entry at or after the current step.
    always_comb begin
        logic found;
        found      = 1'b0;
        sel        = tsed_pkg::SLOT_END;
        final_slot = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (present[i] && (2'(i) >= r_step)) begin
                if (!found) begin
                    sel   = tsed_pkg::t_slot'(2'(i));
                    found = 1'b1;
                end else begin
                    final_slot = 1'b0;
                end
            end
        end
        n_step = final_slot ? 2'd0 : (2'(sel) + 2'd1);
    end

    assign o_pop = load && final_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= n_step;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            case (sel)
                tsed_pkg::SLOT_B0: begin
                    r_byte   <= i_cmd.b0;
                    r_repeat <= tsed_pkg::REPEAT_ONE;
                    r_last   <= 1'b0;
                end
                tsed_pkg::SLOT_B1: begin
                    r_byte   <= i_cmd.b1;
                    r_repeat <= tsed_pkg::REPEAT_ONE;
                    r_last   <= 1'b0;
                end
                tsed_pkg::SLOT_PAD: begin
                    r_byte   <= tsed_pkg::PAD_BYTE;
                    r_repeat <= i_cmd.pad;
                    r_last   <= 1'b0;
                end
                default: begin
                    r_byte   <= tsed_pkg::CHAR_NUL;
                    r_repeat <= tsed_pkg::REPEAT_ONE;
                    r_last   <= 1'b1;
                end
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_byte   = r_byte;
    assign o_repeat = r_repeat;
    assign o_last   = r_last;

endmodule

/* rtl/termcap_string_escape_decoder.sv */
// Decodes a termcap string capability value, one text byte per input request (tuser marks
// the first byte of a value), into output requests of {byte, repeat count}: plain and
// escaped bytes with a count of one, a single 0x80 pad run carrying the leading delay, and a
// terminating NUL marked with tlast. Each byte is decoded in the cycle it is accepted; its
// results go into a four-entry queue. Unless stalled, the input side takes one byte per
// cycle and the output side sends one result per cycle. Most bytes cause at most one
// result, so the sustained rate is one byte per clock; the end of a value causes up to three
// results, and back-to-back ends are paced by the single output register to one result per
// cycle. The pad limit may be written at any time the block is idle; it resets to 100.
module termcap_string_escape_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_in
    input  logic        i_s_tuser,   // [0] start_req
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] byte_out, [15:8] repeat_res
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data   // [7:0] pad_limit
);

    logic [7:0]     r_pad_limit;
    logic           q_full, q_valid, push, pop;
    tsed_pkg::t_cmd push_cmd, head_cmd;
    logic [7:0]     out_byte, out_repeat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_limit <= tsed_pkg::PAD_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_pad_limit <= i_cfg_data;
        end
    end

    tsed_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_char      (i_s_tdata),
        .i_start     (i_s_tuser),
        .i_pad_limit (r_pad_limit),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    tsed_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    tsed_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_byte    (out_byte),
        .o_repeat  (out_repeat),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {out_repeat, out_byte};

endmodule

/* rtl/tsed_checker.sv */
module tsed_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tlast
);

    // Nothing is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // The terminator is always a single NUL.
    a_end_is_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata == 16'h0100)
        else $error("last result is not a single NUL");

    // Only the pad run may carry a count other than one, and never zero.
    a_repeat_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[15:8] != 8'd1 |->
            o_m_tdata[7:0] == 8'h80 && o_m_tdata[15:8] != 8'd0 && !o_m_tlast)
        else $error("bad repeat count");

endmodule

bind termcap_string_escape_decoder tsed_checker u_tsed_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
